// ===== rtl/core/sorted_interval_table_core_defines.svh =====
// Assertion macros for the sorted interval table checker.
// Depends on nothing; every use expects clk_i and rst_ni in scope.
`ifndef SORTED_INTERVAL_TABLE_CORE_DEFINES_SVH
`define SORTED_INTERVAL_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sit_pkg.sv =====
// Shared types and constants of the sorted interval table.
// Used by the controller, the datapath, the top level and the checker.
package sit_pkg;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned DAY_BITS      = 16;
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);

  typedef logic [DAY_BITS-1:0] day_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    OP_INSERT      = 2'd0,
    OP_REMOVE_LAST = 2'd1,
    OP_CLEAR       = 2'd2,
    OP_QUERY       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_APPLY
  } ctrl_state_e;

  typedef struct packed {
    op_e  opcode;
    day_t first_day;
    day_t last_day;
    day_t query_day;
  } in_word_t;

  typedef struct packed {
    status_e status;
    logic    is_free_day;
    cnt_t    entry_count;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the word and the per-slot compare flags
    logic commit;   // apply the operation and load the result register
  } dp_cmd_t;

endpackage

// ===== rtl/core/sit_ctrl.sv =====
// Sequencer of the sorted interval table: handshakes and datapath commands.
// Depends on sit_pkg.
module sit_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sit_pkg::dp_cmd_t cmd_o
);

  sit_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sit_pkg::CTRL_IDLE: begin
        if (in_valid_i) state_d = sit_pkg::CTRL_APPLY;
      end
      sit_pkg::CTRL_APPLY: begin
        // hold until the result register is free
        if (out_free) state_d = sit_pkg::CTRL_IDLE;
      end
      default: state_d = sit_pkg::CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      sit_pkg::CTRL_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sit_pkg::CTRL_APPLY: begin
        cmd_o.commit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sit_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/sit_dp.sv =====
// Datapath of the sorted interval table: slot chain, compare flags, count, result.
// Depends on sit_pkg; driven by sit_ctrl commands.
module sit_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sit_pkg::dp_cmd_t  cmd_i,
  input  sit_pkg::in_word_t in_word_i,
  output sit_pkg::out_word_t out_word_o
);

  localparam int unsigned N = sit_pkg::MAX_INTERVALS;

  sit_pkg::day_t     start_q [N];
  sit_pkg::day_t     end_q   [N];
  sit_pkg::cnt_t     count_q, count_d;
  sit_pkg::in_word_t word_q;
  sit_pkg::out_word_t out_q, out_d;

  // Per-slot flags, computed from the incoming word and latched at capture.
  logic [N-1:0] gt_d, gt_q;        // slot empty or its start above first_day
  logic [N-1:0] ov_start_d, ov_start_q;
  logic [N-1:0] ov_end_d, ov_end_q;
  logic [N-1:0] hit_d, hit_q;

  logic [N-1:0] pos_hot;           // one-hot insert position
  logic [N-1:0] next_hit;
  logic [N-1:0] prev_hit;
  logic         overlap;
  logic         full;
  logic         do_insert;

  for (genvar k = 0; k < N; k++) begin : g_flags
    logic used;
    assign used          = sit_pkg::cnt_t'(k) < count_q;
    assign gt_d[k]       = !used || (in_word_i.first_day < start_q[k]);
    assign ov_start_d[k] = in_word_i.last_day >= start_q[k];
    assign ov_end_d[k]   = in_word_i.first_day <= end_q[k];
    assign hit_d[k]      = used && (start_q[k] <= in_word_i.query_day) &&
                           (in_word_i.query_day <= end_q[k]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q     <= in_word_i;
      gt_q       <= gt_d;
      ov_start_q <= ov_start_d;
      ov_end_q   <= ov_end_d;
      hit_q      <= hit_d;
    end
  end

  // gt_q is a thermometer (starts are nondecreasing); its edge is the position.
  assign pos_hot = gt_q & ~{gt_q[N-2:0], 1'b0};

  // The slot at the position must be in use to count as a following entry.
  for (genvar k = 0; k < N; k++) begin : g_next
    assign next_hit[k] = pos_hot[k] && ov_start_q[k] && (sit_pkg::cnt_t'(k) < count_q);
  end

  // The entry just below the position: clear here, set one slot up.
  assign prev_hit = {1'b0, ~gt_q[N-2:0] & gt_q[N-1:1] & ov_end_q[N-2:0]};

  assign overlap   = |next_hit || |prev_hit;
  assign full      = count_q == sit_pkg::cnt_t'(N);
  assign do_insert = cmd_i.commit && (word_q.opcode == sit_pkg::OP_INSERT) &&
                     !full && !overlap;

  always_comb begin
    count_d           = count_q;
    out_d.status      = sit_pkg::ST_DONE;
    out_d.is_free_day = 1'b0;
    unique case (word_q.opcode)
      sit_pkg::OP_INSERT: begin
        if (full) begin
          out_d.status = sit_pkg::ST_FULL;
        end else if (overlap) begin
          out_d.status = sit_pkg::ST_OVERLAP;
        end else begin
          count_d = count_q + sit_pkg::cnt_t'(1);
        end
      end
      sit_pkg::OP_REMOVE_LAST: begin
        if (count_q != '0) count_d = count_q - sit_pkg::cnt_t'(1);
      end
      sit_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      sit_pkg::OP_QUERY: begin
        out_d.is_free_day = !(|hit_q);
      end
      default: ;
    endcase
    out_d.entry_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= out_d;
  end

  // Slot chain: the position takes the new interval, slots above move up one.
  for (genvar k = 0; k < N; k++) begin : g_slot
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (do_insert && pos_hot[k]) begin
          start_q[k] <= word_q.first_day;
          end_q[k]   <= word_q.last_day;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (do_insert) begin
          if (pos_hot[k]) begin
            start_q[k] <= word_q.first_day;
            end_q[k]   <= word_q.last_day;
          end else if (gt_q[k-1]) begin
            start_q[k] <= start_q[k-1];
            end_q[k]   <= end_q[k-1];
          end
        end
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== rtl/core/sorted_interval_table_core.sv =====
// Sorted interval table: top level joining the controller and the datapath.
// Depends on sit_pkg, sit_ctrl and sit_dp.
//
// Input channel (in_valid_i / in_ready_o / in_word_i) takes one command word:
// insert an interval, remove the last entry, clear, or query a day. The output
// channel (out_valid_o / out_ready_i / out_word_o) returns one result word per
// command: status, free-day flag and the entry count after the command.
// Each word passes a capture step, which latches all per-slot compare flags of
// the 64-slot chain, and then an apply step, which does the insert shift or
// count update and loads the result register; apply waits while an earlier
// result is stalled, and no new word is taken before apply is done.
// The input is taken again as soon as the command has been applied, even while
// the result still waits; a second result waits in the apply step until the
// receiver takes the first, so a stalled receiver stops the input after one
// word.
// Reset empties the table (count to zero) and drops any pending result; slot
// contents are not cleared and are never read until written.
module sorted_interval_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sit_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sit_pkg::out_word_t out_word_o
);

  sit_pkg::dp_cmd_t cmd;

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sit_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== rtl/core/sit_checker.sv =====
// Port-level checks of the sorted interval table, bound to the top level.
// Depends on sit_pkg and sorted_interval_table_core_defines.svh.
`include "sorted_interval_table_core_defines.svh"

module sit_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sit_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sit_pkg::out_word_t out_word_o
);

  // a stalled result word holds
  `SIT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o), "result word changed while stalled")

  // one word at a time: input closes right after an accept
  `SIT_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "input accepted on back-to-back cycles")

  `SIT_ASSERT_NOW(a_count_range, out_valid_o, out_word_o.entry_count <= sit_pkg::cnt_t'(sit_pkg::MAX_INTERVALS), "entry count above table size")

  // a rejected insert never reports a free day
  `SIT_ASSERT_NOW(a_reject_not_free, out_valid_o && (out_word_o.status != sit_pkg::ST_DONE), !out_word_o.is_free_day, "free-day flag set on a rejected insert")

endmodule

bind sorted_interval_table_core sit_checker u_sit_checker (.*);
